### hdl/idfs_pkg.sv
package idfs_pkg;

  localparam int unsigned IdW     = 30;
  localparam int unsigned StatusW = 2;

  // Counter limit after reset
  localparam logic [IdW-1:0] IdLimitReset = IdW'(1) << 29;

  typedef enum logic {
    OpAlloc   = 1'b0,
    OpRelease = 1'b1
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StOk        = 2'd0,
    StExhausted = 2'd1,
    StFull      = 2'd2
  } status_e;

  // One request item
  typedef struct packed {
    op_e            op;
    logic [IdW-1:0] release_id;
  } req_t;

  // One result item
  typedef struct packed {
    logic [IdW-1:0] granted_id;
    status_e        status;
  } rsp_t;

  // Outcome of one request, carried until the stack read data returns
  typedef struct packed {
    logic           pop;
    logic [IdW-1:0] granted;
    status_e        status;
  } act_t;

endpackage

### hdl/idfs_ram.sv
module idfs_ram #(
  parameter int unsigned Width = 30,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/idfs_state.sv
module idfs_state #(
  parameter int unsigned FreeDepth = 1024,
  localparam int unsigned AddrW    = $clog2(FreeDepth),
  localparam int unsigned CntW     = $clog2(FreeDepth + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [idfs_pkg::IdW-1:0]    cfg_wdata_i,
  input  logic                        accept_i,
  input  idfs_pkg::req_t              req_i,
  output idfs_pkg::act_t              act_o,
  output logic                        push_o,
  output logic [AddrW-1:0]            push_addr_o,
  output logic                        pop_o,
  output logic [AddrW-1:0]            pop_addr_o
);

  logic [idfs_pkg::IdW-1:0] id_limit_q, high_water_q, high_water_d;
  logic [CntW-1:0]          free_count_q, free_count_d;
  logic                     stack_empty, stack_full;
  logic [CntW-1:0]          count_dec;

  assign stack_empty = (free_count_q == '0);
  assign stack_full  = (free_count_q >= CntW'(FreeDepth));
  assign count_dec   = free_count_q - CntW'(1);

  assign pop_addr_o  = count_dec[AddrW-1:0];
  assign push_addr_o = free_count_q[AddrW-1:0];

  // Decide the outcome of the request from the current state
  always_comb begin
    act_o.pop     = 1'b0;
    act_o.granted = '0;
    act_o.status  = idfs_pkg::StOk;
    push_o        = 1'b0;
    pop_o         = 1'b0;
    high_water_d  = high_water_q;
    free_count_d  = free_count_q;
    case (req_i.op)
      idfs_pkg::OpAlloc: begin
        if (!stack_empty) begin
          act_o.pop    = 1'b1;
          pop_o        = accept_i;
          free_count_d = count_dec;
        end else if (high_water_q < id_limit_q) begin
          high_water_d  = high_water_q + idfs_pkg::IdW'(1);
          act_o.granted = high_water_d;
        end else begin
          act_o.status = idfs_pkg::StExhausted;
        end
      end
      idfs_pkg::OpRelease: begin
        if (req_i.release_id == '0) begin
          // release of zero is ignored
        end else if (req_i.release_id == high_water_q) begin
          high_water_d = high_water_q - idfs_pkg::IdW'(1);
        end else if (!stack_full) begin
          push_o       = accept_i;
          free_count_d = free_count_q + CntW'(1);
        end else begin
          act_o.status = idfs_pkg::StFull;
        end
      end
      default: begin
        act_o.status = idfs_pkg::StOk;
      end
    endcase
  end

  // Hold the limit and advance counters on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_limit_q   <= idfs_pkg::IdLimitReset;
      high_water_q <= '0;
      free_count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        id_limit_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        high_water_q <= high_water_d;
        free_count_q <= free_count_d;
      end
    end
  end

endmodule

### hdl/id_allocator_free_stack_unit.sv
// Items pass a mid stage (outcome held, RAM read) and then the result register.
// Throughput: one item per cycle, back to back, unless the output stalls; the
// stack pointer and counter update at acceptance, RAM read data registered once.
// Reset: high-water counter and stack count clear, the limit returns to 1<<29;
// stack RAM contents stay undefined and need no clearing pass.
module id_allocator_free_stack_unit #(
  parameter int unsigned FreeDepth = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [idfs_pkg::IdW-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  idfs_pkg::req_t           in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output idfs_pkg::rsp_t           out_data_o
);

  localparam int unsigned AddrW = $clog2(FreeDepth);

  logic                     accept;
  idfs_pkg::act_t           act, act_q;
  logic                     push, pop;
  logic [AddrW-1:0]         push_addr, pop_addr;
  logic [idfs_pkg::IdW-1:0] rdata;
  logic                     mid_valid_q, out_valid_q;
  logic                     mid_advance;
  idfs_pkg::rsp_t           out_q;

  assign mid_advance = mid_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !mid_valid_q || mid_advance;
  assign accept      = in_valid_i && in_ready_o;

  idfs_state #(
    .FreeDepth(FreeDepth)
  ) u_state (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .accept_i    (accept),
    .req_i       (in_data_i),
    .act_o       (act),
    .push_o      (push),
    .push_addr_o (push_addr),
    .pop_o       (pop),
    .pop_addr_o  (pop_addr)
  );

  idfs_ram #(
    .Width(idfs_pkg::IdW),
    .Depth(FreeDepth)
  ) u_ram (
    .clk_i,
    .we_i    (push),
    .waddr_i (push_addr),
    .wdata_i (in_data_i.release_id),
    .re_i    (pop),
    .raddr_i (pop_addr),
    .rdata_o (rdata)
  );

  // Hold the outcome while the stack read completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      mid_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= act;
    end
  end

  // Result register: pick popped ID or counter value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= mid_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_advance) begin
      out_q.granted_id <= act_q.pop ? rdata : act_q.granted;
      out_q.status     <= act_q.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### bench/tb_id_allocator_free_stack_unit.sv
module tb_id_allocator_free_stack_unit;

  localparam int unsigned FreeDepth   = 1024;
  localparam int unsigned PipeLatency = 2;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned StuckLimit  = 4000;
  localparam logic [idfs_pkg::IdW-1:0] IdMax = '1;

  logic                     clk_i;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_we_i    = 1'b0;
  logic [idfs_pkg::IdW-1:0] cfg_wdata_i = '0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  idfs_pkg::req_t           in_data_i   = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  idfs_pkg::rsp_t           out_data_o;

  // Shadow allocator state
  logic [idfs_pkg::IdW-1:0] cur_id_limit = idfs_pkg::IdLimitReset;
  logic [idfs_pkg::IdW-1:0] mark         = '0;
  int unsigned              stack_fill   = 0;
  logic [idfs_pkg::IdW-1:0] stacked_ids [FreeDepth];

  // Outcomes of accepted requests, oldest first
  idfs_pkg::rsp_t           outcome_q [$];
  idfs_pkg::rsp_t           oldest_outcome;
  // IDs the traffic generator currently owns
  logic [idfs_pkg::IdW-1:0] held_ids [$];

  // Traffic shaping
  bit             tx_idle_en  = 1'b1;
  bit             rx_stall_en = 1'b1;
  bit             rx_hold_req = 1'b0;
  int unsigned    hold_left   = 0;

  int unsigned    fail_cnt     = 0;
  int unsigned    stuck_cycles = 0;
  int unsigned    n_items      = 0;
  int unsigned    n_grants     = 0;
  int unsigned    n_exhausted  = 0;
  int unsigned    n_dropped    = 0;
  int unsigned    n_limits     = 0;

  id_allocator_free_stack_unit #(
    .FreeDepth(FreeDepth)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Apply one request to the shadow state and return the result it yields
  function automatic idfs_pkg::rsp_t predict_outcome(input idfs_pkg::req_t req);
    idfs_pkg::rsp_t r;
    r.granted_id = '0;
    r.status     = idfs_pkg::StOk;
    if (req.op == idfs_pkg::OpAlloc) begin
      if (stack_fill > 0) begin
        stack_fill--;
        r.granted_id = stacked_ids[stack_fill];
      end else if (mark < cur_id_limit) begin
        mark++;
        r.granted_id = mark;
      end else begin
        r.status = idfs_pkg::StExhausted;
      end
    end else begin
      if (req.release_id == '0) begin
        // zero is never granted; drop it silently
      end else if (req.release_id == mark) begin
        mark--;
      end else if (stack_fill < FreeDepth) begin
        stacked_ids[stack_fill] = req.release_id;
        stack_fill++;
      end else begin
        r.status = idfs_pkg::StFull;
      end
    end
    return r;
  endfunction

  // Offer one item, wait for acceptance, then record its outcome
  task automatic send_request(input idfs_pkg::op_e op,
                              input logic [idfs_pkg::IdW-1:0] id);
    idfs_pkg::req_t req;
    idfs_pkg::rsp_t outcome;
    req.op         = op;
    req.release_id = id;
    if (tx_idle_en && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    outcome = predict_outcome(req);
    outcome_q.push_back(outcome);
    n_items++;
    if (outcome.status == idfs_pkg::StExhausted) n_exhausted++;
    if (outcome.status == idfs_pkg::StFull) n_dropped++;
    if (op == idfs_pkg::OpAlloc && outcome.status == idfs_pkg::StOk) begin
      n_grants++;
      held_ids.push_back(outcome.granted_id);
    end
  endtask

  // Drop valid and wait until every outstanding result is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outcome_q.size() != 0);
    repeat (PipeLatency + 2) @(posedge clk_i);
  endtask

  task automatic write_id_limit(input logic [idfs_pkg::IdW-1:0] limit);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    cur_id_limit = limit;
    n_limits++;
  endtask

  // Mostly well-formed alloc/free traffic, with some stray releases mixed in
  task automatic run_random_mix(input int unsigned n_req);
    int unsigned              pick;
    int unsigned              slot;
    logic [idfs_pkg::IdW-1:0] rid;
    repeat (n_req) begin
      pick = $urandom_range(99);
      if (pick < 50 || (pick < 90 && held_ids.size() == 0)) begin
        send_request(idfs_pkg::OpAlloc, idfs_pkg::IdW'($urandom()));
      end else if (pick < 90) begin
        slot = $urandom_range(held_ids.size() - 1);
        rid  = held_ids[slot];
        held_ids.delete(slot);
        send_request(idfs_pkg::OpRelease, rid);
      end else begin
        case ($urandom_range(3))
          0:       rid = '0;
          1:       rid = mark;
          2:       rid = idfs_pkg::IdW'($urandom());
          default: rid = idfs_pkg::IdW'($urandom_range(64, 1));
        endcase
        send_request(idfs_pkg::OpRelease, rid);
      end
    end
  endtask

  // Counter grants, zero release, mark release, pops in LIFO order, lowered mark
  task automatic test_directed_basics();
    send_request(idfs_pkg::OpAlloc, IdMax);
    send_request(idfs_pkg::OpAlloc, '0);
    send_request(idfs_pkg::OpAlloc, 30'h2AAAAAAA);
    send_request(idfs_pkg::OpRelease, '0);
    send_request(idfs_pkg::OpRelease, 30'd3);
    send_request(idfs_pkg::OpRelease, 30'd1);
    send_request(idfs_pkg::OpRelease, IdMax);
    send_request(idfs_pkg::OpRelease, 30'h2AAAAAAA);
    send_request(idfs_pkg::OpRelease, 30'h15555555);
    repeat (4) send_request(idfs_pkg::OpAlloc, 30'h15555555);
    send_request(idfs_pkg::OpAlloc, '0);
    send_request(idfs_pkg::OpRelease, 30'd2);
    send_request(idfs_pkg::OpRelease, 30'd3);
    send_request(idfs_pkg::OpAlloc, '0);
    // these IDs were handed back by hand; forget them
    held_ids.delete();
  endtask

  // Exhaustion at limit zero, one, just above the mark, and the extremes
  task automatic test_limit_edges();
    write_id_limit('0);
    send_request(idfs_pkg::OpAlloc, '0);
    send_request(idfs_pkg::OpRelease, mark);
    send_request(idfs_pkg::OpAlloc, '0);
    write_id_limit(mark + 1'b1);
    send_request(idfs_pkg::OpAlloc, '0);
    send_request(idfs_pkg::OpAlloc, '0);
    write_id_limit(30'd1);
    send_request(idfs_pkg::OpAlloc, '0);
    write_id_limit(IdMax);
    send_request(idfs_pkg::OpAlloc, '0);
    write_id_limit(idfs_pkg::IdLimitReset);
    send_request(idfs_pkg::OpAlloc, '0);
  endtask

  // Fill the free stack, overflow it, release the mark while full, pop a few
  task automatic test_full_stack();
    logic [idfs_pkg::IdW-1:0] rid;
    while (stack_fill < FreeDepth) begin
      do rid = idfs_pkg::IdW'($urandom()); while (rid == '0 || rid == mark);
      send_request(idfs_pkg::OpRelease, rid);
    end
    repeat (3) begin
      do rid = idfs_pkg::IdW'($urandom()); while (rid == '0 || rid == mark);
      send_request(idfs_pkg::OpRelease, rid);
    end
    send_request(idfs_pkg::OpRelease, mark);
    repeat (8) send_request(idfs_pkg::OpAlloc, idfs_pkg::IdW'($urandom()));
    // keep only a few so the counter stays in play afterwards
    while (held_ids.size() > 8) void'(held_ids.pop_back());
  endtask

  task automatic test_small_limit_mix();
    write_id_limit(30'd16);
    run_random_mix(40);
  endtask

  // Hold the output off while the input keeps offering items
  task automatic test_output_hold();
    rx_hold_req = 1'b1;
    tx_idle_en  = 1'b0;
    run_random_mix(30);
    tx_idle_en  = 1'b1;
    wait_drained();
  endtask

  // Pause the input until everything in flight has come back
  task automatic test_input_pause();
    run_random_mix(10);
    wait_drained();
    run_random_mix(10);
  endtask

  task automatic test_back_to_back();
    write_id_limit(idfs_pkg::IdLimitReset);
    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b0;
    run_random_mix(50);
    tx_idle_en  = 1'b1;
    rx_stall_en = 1'b1;
  endtask

  task automatic test_wide_limits();
    write_id_limit(IdMax);
    run_random_mix(15);
    write_id_limit(idfs_pkg::IdW'($urandom_range(64, 1)));
    run_random_mix(25);
  endtask

  // Result ready: random stalls, or a long hold when requested
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      hold_left   = HoldCycles;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !(rx_stall_en && $urandom_range(99) < 15);
    end
  end

  // Compare each result against the oldest outcome
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (outcome_q.size() == 0) begin
        $error("result with none pending: granted_id %0h status %0d",
               out_data_o.granted_id, out_data_o.status);
        fail_cnt++;
      end else begin
        oldest_outcome = outcome_q.pop_front();
        if (out_data_o.granted_id !== oldest_outcome.granted_id) begin
          $error("granted_id mismatch: expected %0h, actual %0h",
                 oldest_outcome.granted_id, out_data_o.granted_id);
          fail_cnt++;
        end
        if (out_data_o.status !== oldest_outcome.status) begin
          $error("status mismatch: expected %0d, actual %0d",
                 oldest_outcome.status, out_data_o.status);
          fail_cnt++;
        end
      end
    end
  end

  // End the run when nothing has moved for too long
  initial begin
    while (stuck_cycles < StuckLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
    end
    $display("id_allocator_free_stack_unit test failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_basics();
    test_limit_edges();
    test_small_limit_mix();
    test_output_hold();
    test_input_pause();
    test_back_to_back();
    test_wide_limits();
    test_full_stack();
    wait_drained();
    $display("Sent %0d requests: %0d grants, %0d exhausted, %0d dropped pushes.",
             n_items, n_grants, n_exhausted, n_dropped);
    $display("Used %0d id_limit writes, a full free stack and a long output hold.",
             n_limits);
    if (fail_cnt == 0) begin
      $display("id_allocator_free_stack_unit test passed");
    end else begin
      $display("id_allocator_free_stack_unit test failed");
    end
    $finish;
  end

endmodule

### files.f
hdl/idfs_pkg.sv
hdl/idfs_ram.sv
hdl/idfs_state.sv
hdl/id_allocator_free_stack_unit.sv
bench/tb_id_allocator_free_stack_unit.sv
